[rtl/etx_pkg.sv]
`default_nettype none
package etx_pkg;
    localparam int MAX_NEIGHBORS = 10;
    localparam int WINDOW = 30;

    localparam int ADDR_W = 32;
    localparam int CNT8_W = 8;
    localparam int COST_W = 20;
    localparam int IDX_W = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int PCNT_W = $clog2(MAX_NEIGHBORS + 1);
    localparam int COL_W = $clog2(WINDOW);
    localparam int WDEPTH = MAX_NEIGHBORS * WINDOW;
    localparam int WADDR_W = $clog2(WDEPTH);
    localparam int NUM_W = $clog2(WINDOW * WINDOW + 1);
    localparam int PROD_W = 2 * CNT8_W;
    localparam int DCNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    localparam logic [NUM_W-1:0] COST_NUM = NUM_W'(WINDOW * WINDOW);
    localparam logic [COST_W-1:0] COST_INF = COST_W'(1000000);
    localparam logic [CNT8_W-1:0] INIT_COUNT = CNT8_W'(30);
    localparam logic [CNT8_W-1:0] CNT_MAX = '1;

    localparam int IN_TDATA_W = 112;
    localparam int OUT_TDATA_W = 56;

    localparam logic [1:0] REQ_HEADER = 2'd0;
    localparam logic [1:0] REQ_ENTRY = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;
    localparam logic [1:0] REQ_QUERY = 2'd3;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_COST = 2'd1;
    localparam logic [1:0] KIND_OUTGOING = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOT_LISTED = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
endpackage
`default_nettype wire

[rtl/etx_ram.sv]
`default_nettype none
module etx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                     clk,
    input  wire                     wr_en,
    input  wire [$clog2(DEPTH)-1:0] wr_addr,
    input  wire [WIDTH-1:0]         wr_data,
    input  wire [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]        rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

[rtl/link_etx_neighbor_table.sv]
// Channel   Dir  Beat contents
// s_axis    in   tuser req_type; tlast entry_last; tdata source/entry/query fields
// m_axis    out  tuser result_kind; tlast last_result; tdata status/address/value
// cfg       in   host_address_we / host_address_wdata, one register
//
// After reset a clearing pass over all MAX_NEIGHBORS*WINDOW (300) window memory words
// loads each with its initial count; no beat is taken meanwhile.
// One item at a time. A search reads the peer memory port entry by entry, a read state
// then a compare per entry. A header then reads and writes back each window slot
// of a known neighbor (window memory port), or writes each slot once for a new neighbor.
// A tick reads, multiplies and divides bit by bit per neighbor, then reads and emits each
// outgoing beat. A pending output beat stalls only the next emit.
`default_nettype none
module link_etx_neighbor_table (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         host_address_we,
    input  wire [31:0]  host_address_wdata,
    input  wire         s_tvalid,
    output logic        s_tready,
    // tdata: source_address[31:0], no_entries[32], entry_address[64:33],
    //        entry_count[72:65], query_address[104:73], zero fill
    input  wire [etx_pkg::IN_TDATA_W-1:0] s_tdata,
    input  wire [1:0]   s_tuser,    // req_type
    input  wire         s_tlast,    // entry_last
    output logic        m_tvalid,
    input  wire         m_tready,
    // tdata: status[1:0], neighbor_address[33:2], result_value[53:34], zero fill
    output logic [etx_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic [1:0]  m_tuser,    // result_kind
    output logic        m_tlast     // last_result
);
    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_SRCH_RD, S_SRCH_CMP, S_MISS, S_NEW, S_FILL,
        S_INC_RD, S_INC_WR, S_P_DONE, S_ENTRY, S_ENTRY_RD, S_ENTRY_CAP,
        S_T_RD, S_T_MUL, S_T_DIV, S_O_RD, S_O_CAP, S_EMIT
    } state_t;

    state_t state_reg, ret_reg;

    logic [31:0] host_reg;
    logic [1:0]  op_reg;
    logic [31:0] src_reg, eaddr_reg, qaddr_reg;
    logic        noent_reg, elast_reg;
    logic [7:0]  ecount_reg;

    logic [etx_pkg::PCNT_W-1:0] peer_count_reg;
    logic [etx_pkg::IDX_W-1:0]  idx_reg, slot_reg;
    logic                       slot_ok_reg, host_seen_reg;
    logic [etx_pkg::COL_W-1:0]  col_reg;
    logic [etx_pkg::WADDR_W-1:0] clr_reg;

    logic [etx_pkg::COL_W-1:0]  head_reg [etx_pkg::MAX_NEIGHBORS];
    logic [7:0]                 fwd_reg [etx_pkg::MAX_NEIGHBORS];
    logic [etx_pkg::COST_W-1:0] cost_reg [etx_pkg::MAX_NEIGHBORS];

    logic [etx_pkg::PROD_W-1:0] prod_reg;
    logic                       zero_reg;
    logic [etx_pkg::PROD_W:0]   rem_reg;
    logic [etx_pkg::NUM_W-1:0]  quo_reg;
    logic [etx_pkg::DCNT_W-1:0] dcnt_reg;

    logic [1:0]  pend_kind_reg, pend_status_reg;
    logic [31:0] pend_addr_reg;
    logic [etx_pkg::COST_W-1:0] pend_value_reg;
    logic        pend_last_reg;

    logic        m_valid_reg, m_last_reg;
    logic [1:0]  m_kind_reg, m_status_reg;
    logic [31:0] m_addr_reg;
    logic [etx_pkg::COST_W-1:0] m_value_reg;

    // Memory ports.
    logic        peer_we;
    logic [31:0] peer_rdata;
    logic        win_we;
    logic [7:0]  win_wdata, win_rdata;
    logic [etx_pkg::WADDR_W-1:0] win_addr;
    logic [etx_pkg::COL_W-1:0]   col;

    logic        in_acc, out_free, more_peers, host_hit;
    logic [31:0] key;
    logic [etx_pkg::PROD_W:0]   trial;
    logic                       trial_ge;
    logic [etx_pkg::NUM_W-1:0]  quo_next;

    assign in_acc = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_tready;
    assign more_peers = (etx_pkg::PCNT_W'(idx_reg) + 1'b1) < peer_count_reg;
    assign key = (op_reg == etx_pkg::REQ_QUERY) ? qaddr_reg : src_reg;
    assign host_hit = !host_seen_reg && (eaddr_reg == host_reg);

    always_comb
    begin
        case (state_reg)
            S_T_RD, S_T_MUL, S_O_RD: col = head_reg[idx_reg];
            default:                 col = col_reg;
        endcase
    end

    assign win_addr = (state_reg == S_CLEAR) ? clr_reg :
        etx_pkg::WADDR_W'(etx_pkg::WADDR_W'(idx_reg) * etx_pkg::WADDR_W'(etx_pkg::WINDOW))
        + etx_pkg::WADDR_W'(col);

    always_comb
    begin
        win_we = 1'b0;
        win_wdata = '0;
        case (state_reg)
            S_CLEAR:
            begin
                win_we = 1'b1;
                win_wdata = etx_pkg::INIT_COUNT;
            end
            S_FILL:
            begin
                win_we = 1'b1;
                win_wdata = 8'd1;
            end
            S_INC_WR:
            begin
                win_we = 1'b1;
                win_wdata = (win_rdata == etx_pkg::CNT_MAX) ? win_rdata : win_rdata + 8'd1;
            end
            S_T_MUL:
            begin
                win_we = 1'b1;
            end
            default:
            begin
                win_we = 1'b0;
            end
        endcase
    end

    assign peer_we = (state_reg == S_NEW);

    // One restoring division step per cycle, numerator bit from the constant.
    assign trial = {rem_reg[etx_pkg::PROD_W-1:0], etx_pkg::COST_NUM[dcnt_reg]};
    assign trial_ge = trial >= {1'b0, prod_reg};
    always_comb
    begin
        quo_next = quo_reg;
        quo_next[dcnt_reg] = trial_ge;
    end

    etx_ram #(.WIDTH(32), .DEPTH(etx_pkg::MAX_NEIGHBORS)) u_peer_ram (
        .clk     (clk),
        .wr_en   (peer_we),
        .wr_addr (idx_reg),
        .wr_data (src_reg),
        .rd_addr (idx_reg),
        .rd_data (peer_rdata)
    );

    etx_ram #(.WIDTH(8), .DEPTH(etx_pkg::WDEPTH)) u_win_ram (
        .clk     (clk),
        .wr_en   (win_we),
        .wr_addr (win_addr),
        .wr_data (win_wdata),
        .rd_addr (win_addr),
        .rd_data (win_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ret_reg <= S_IDLE;
            host_reg <= '0;
            peer_count_reg <= '0;
            idx_reg <= '0;
            slot_reg <= '0;
            slot_ok_reg <= 1'b0;
            host_seen_reg <= 1'b0;
            col_reg <= '0;
            clr_reg <= '0;
            dcnt_reg <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < etx_pkg::MAX_NEIGHBORS; i++)
            begin
                head_reg[i] <= '0;
                fwd_reg[i] <= etx_pkg::INIT_COUNT;
                cost_reg[i] <= '0;
            end
        end
        else
        begin
            if (host_address_we)
            begin
                host_reg <= host_address_wdata;
            end
            // The emit state loads the output register itself.
            if (m_valid_reg && m_tready && state_reg != S_EMIT)
            begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == etx_pkg::WADDR_W'(etx_pkg::WDEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        op_reg <= s_tuser;
                        src_reg <= s_tdata[31:0];
                        noent_reg <= s_tdata[32];
                        eaddr_reg <= s_tdata[64:33];
                        ecount_reg <= s_tdata[72:65];
                        qaddr_reg <= s_tdata[104:73];
                        elast_reg <= s_tlast;
                        idx_reg <= '0;
                        case (s_tuser)
                            etx_pkg::REQ_HEADER, etx_pkg::REQ_QUERY:
                            begin
                                if (s_tuser == etx_pkg::REQ_HEADER)
                                begin
                                    slot_ok_reg <= 1'b0;
                                    host_seen_reg <= 1'b0;
                                end
                                state_reg <= (peer_count_reg == '0) ? S_MISS : S_SRCH_RD;
                            end
                            etx_pkg::REQ_ENTRY:
                            begin
                                state_reg <= S_ENTRY;
                            end
                            default:
                            begin
                                state_reg <= (peer_count_reg == '0) ? S_IDLE : S_T_RD;
                            end
                        endcase
                    end
                end
                S_SRCH_RD:
                begin
                    state_reg <= S_SRCH_CMP;
                end
                S_SRCH_CMP:
                begin
                    if (peer_rdata == key)
                    begin
                        if (op_reg == etx_pkg::REQ_QUERY)
                        begin
                            pend_kind_reg <= etx_pkg::KIND_COST;
                            pend_status_reg <= etx_pkg::ST_OK;
                            pend_addr_reg <= qaddr_reg;
                            pend_value_reg <= cost_reg[idx_reg];
                            pend_last_reg <= 1'b0;
                            ret_reg <= S_IDLE;
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            col_reg <= '0;
                            state_reg <= S_INC_RD;
                        end
                    end
                    else if (more_peers)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        state_reg <= S_SRCH_RD;
                    end
                    else
                    begin
                        state_reg <= S_MISS;
                    end
                end
                S_MISS:
                begin
                    pend_last_reg <= 1'b0;
                    ret_reg <= S_IDLE;
                    if (op_reg == etx_pkg::REQ_QUERY)
                    begin
                        pend_kind_reg <= etx_pkg::KIND_COST;
                        pend_status_reg <= etx_pkg::ST_NOT_LISTED;
                        pend_addr_reg <= qaddr_reg;
                        pend_value_reg <= etx_pkg::COST_INF;
                        state_reg <= S_EMIT;
                    end
                    else if (peer_count_reg == etx_pkg::PCNT_W'(etx_pkg::MAX_NEIGHBORS))
                    begin
                        pend_kind_reg <= etx_pkg::KIND_STATUS;
                        pend_status_reg <= etx_pkg::ST_FULL;
                        pend_addr_reg <= src_reg;
                        pend_value_reg <= '0;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        idx_reg <= peer_count_reg[etx_pkg::IDX_W-1:0];
                        state_reg <= S_NEW;
                    end
                end
                S_NEW:
                begin
                    col_reg <= '0;
                    peer_count_reg <= peer_count_reg + 1'b1;
                    state_reg <= S_FILL;
                end
                S_FILL:
                begin
                    col_reg <= col_reg + 1'b1;
                    if (col_reg == etx_pkg::COL_W'(etx_pkg::WINDOW - 1))
                    begin
                        state_reg <= S_P_DONE;
                    end
                end
                S_INC_RD:
                begin
                    state_reg <= S_INC_WR;
                end
                S_INC_WR:
                begin
                    col_reg <= col_reg + 1'b1;
                    state_reg <= (col_reg == etx_pkg::COL_W'(etx_pkg::WINDOW - 1))
                        ? S_P_DONE : S_INC_RD;
                end
                S_P_DONE:
                begin
                    if (noent_reg)
                    begin
                        pend_kind_reg <= etx_pkg::KIND_STATUS;
                        pend_status_reg <= etx_pkg::ST_NOT_LISTED;
                        pend_addr_reg <= src_reg;
                        pend_value_reg <= '0;
                        pend_last_reg <= 1'b0;
                        ret_reg <= S_IDLE;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        slot_reg <= idx_reg;
                        slot_ok_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_ENTRY:
                begin
                    if (!slot_ok_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        if (host_hit)
                        begin
                            fwd_reg[slot_reg] <= ecount_reg;
                            host_seen_reg <= 1'b1;
                        end
                        idx_reg <= slot_reg;
                        state_reg <= elast_reg ? S_ENTRY_RD : S_IDLE;
                    end
                end
                S_ENTRY_RD:
                begin
                    state_reg <= S_ENTRY_CAP;
                end
                S_ENTRY_CAP:
                begin
                    pend_kind_reg <= etx_pkg::KIND_STATUS;
                    pend_status_reg <= host_seen_reg ? etx_pkg::ST_OK : etx_pkg::ST_NOT_LISTED;
                    pend_addr_reg <= peer_rdata;
                    pend_value_reg <= '0;
                    pend_last_reg <= 1'b0;
                    slot_ok_reg <= 1'b0;
                    host_seen_reg <= 1'b0;
                    ret_reg <= S_IDLE;
                    state_reg <= S_EMIT;
                end
                S_T_RD:
                begin
                    state_reg <= S_T_MUL;
                end
                S_T_MUL:
                begin
                    // The head slot is cleared by this cycle's write.
                    prod_reg <= win_rdata * fwd_reg[idx_reg];
                    zero_reg <= (win_rdata == '0) || (fwd_reg[idx_reg] == '0);
                    head_reg[idx_reg] <= (head_reg[idx_reg] == etx_pkg::COL_W'(etx_pkg::WINDOW - 1))
                        ? '0 : head_reg[idx_reg] + 1'b1;
                    rem_reg <= '0;
                    quo_reg <= '0;
                    dcnt_reg <= etx_pkg::DCNT_W'(etx_pkg::NUM_W - 1);
                    state_reg <= S_T_DIV;
                end
                S_T_DIV:
                begin
                    rem_reg <= trial_ge ? trial - {1'b0, prod_reg} : trial;
                    quo_reg <= quo_next;
                    dcnt_reg <= dcnt_reg - 1'b1;
                    if (dcnt_reg == '0)
                    begin
                        cost_reg[idx_reg] <= zero_reg ? etx_pkg::COST_INF
                                                      : etx_pkg::COST_W'(quo_next);
                        if (more_peers)
                        begin
                            idx_reg <= idx_reg + 1'b1;
                            state_reg <= S_T_RD;
                        end
                        else
                        begin
                            idx_reg <= '0;
                            state_reg <= S_O_RD;
                        end
                    end
                end
                S_O_RD:
                begin
                    state_reg <= S_O_CAP;
                end
                S_O_CAP:
                begin
                    pend_kind_reg <= etx_pkg::KIND_OUTGOING;
                    pend_status_reg <= etx_pkg::ST_OK;
                    pend_addr_reg <= peer_rdata;
                    pend_value_reg <= etx_pkg::COST_W'(win_rdata);
                    pend_last_reg <= !more_peers;
                    ret_reg <= more_peers ? S_O_RD : S_IDLE;
                    if (more_peers)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_kind_reg <= pend_kind_reg;
                        m_status_reg <= pend_status_reg;
                        m_addr_reg <= pend_addr_reg;
                        m_value_reg <= pend_value_reg;
                        m_last_reg <= pend_last_reg;
                        state_reg <= ret_reg;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser = m_kind_reg;
    assign m_tlast = m_last_reg;
    assign m_tdata = {2'b00, m_value_reg, m_addr_reg, m_status_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        peer_count_reg <= etx_pkg::PCNT_W'(etx_pkg::MAX_NEIGHBORS))
        else $error("neighbor count above table size");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        peer_count_reg != $past(peer_count_reg) |->
            peer_count_reg == $past(peer_count_reg) + 1'b1)
        else $error("neighbor count moved by other than one");
    a_slot_valid: assert property (@(posedge clk) disable iff (!rst_n)
        slot_ok_reg |-> etx_pkg::PCNT_W'(slot_reg) < peer_count_reg)
        else $error("open probe points past the table");
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !m_valid_reg && !s_tready)
        else $error("traffic during clearing pass");
endmodule
`default_nettype wire

[test/link_etx_neighbor_table_tb.sv]
`timescale 1ns / 100ps
module link_etx_neighbor_table_tb;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [31:0] addr;
        logic [19:0] value;
        logic        last;
    } etx_result_t;

    typedef struct {
        logic [1:0]  req;
        logic [31:0] src;
        logic        no_entries;
        logic [31:0] eaddr;
        logic [7:0]  ecount;
        logic        elast;
        logic [31:0] qaddr;
        logic        has_fixed;
        etx_result_t fixed;
    } probe_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic host_address_we = 1'b0;
    logic [31:0] host_address_wdata = '0;
    logic s_tvalid = 1'b0;
    wire s_tready;
    logic [etx_pkg::IN_TDATA_W-1:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic s_tlast = 1'b0;
    wire m_tvalid;
    logic m_tready = 1'b0;
    wire [etx_pkg::OUT_TDATA_W-1:0] m_tdata;
    wire [1:0] m_tuser;
    wire m_tlast;

    link_etx_neighbor_table u_dut (
        .clk(clk), .rst_n(rst_n),
        .host_address_we(host_address_we), .host_address_wdata(host_address_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always #10 clk = ~clk;

    // Shadow copy of the neighbor table.
    logic [31:0] nb_host;
    logic [31:0] nb_addr [etx_pkg::MAX_NEIGHBORS];
    int          nb_count;
    logic [7:0]  nb_win [etx_pkg::MAX_NEIGHBORS][etx_pkg::WINDOW];
    int          nb_head [etx_pkg::MAX_NEIGHBORS];
    logic [7:0]  nb_fwd [etx_pkg::MAX_NEIGHBORS];
    logic [19:0] nb_cost [etx_pkg::MAX_NEIGHBORS];
    int          open_slot;
    bit          open_ok;
    bit          host_heard;

    etx_result_t pending_results [$];
    int errors = 0;
    longint cycles = 0;
    bit quiet = 0;
    int stall_left = 0;

    function automatic etx_result_t mk(logic [1:0] k, logic [1:0] s, logic [31:0] a,
                                       logic [19:0] v, logic l);
        etx_result_t r;
        r.kind = k; r.status = s; r.addr = a; r.value = v; r.last = l;
        return r;
    endfunction

    function automatic int lookup_neighbor(logic [31:0] a);
        for (int i = 0; i < nb_count; i++)
            if (nb_addr[i] == a) return i;
        return -1;
    endfunction

    task automatic table_reset();
        nb_host = '0;
        nb_count = 0;
        for (int i = 0; i < etx_pkg::MAX_NEIGHBORS; i++)
        begin
            for (int j = 0; j < etx_pkg::WINDOW; j++) nb_win[i][j] = 8'd30;
            nb_head[i] = 0;
            nb_fwd[i] = 8'd30;
            nb_cost[i] = '0;
        end
        open_slot = 0;
        open_ok = 0;
        host_heard = 0;
    endtask

    task automatic update_table(probe_row_t it);
        int s;
        int h;
        int r;
        int f;
        case (it.req)
            etx_pkg::REQ_HEADER:
            begin
                s = lookup_neighbor(it.src);
                open_ok = 0;
                host_heard = 0;
                if (s >= 0)
                begin
                    for (int j = 0; j < etx_pkg::WINDOW; j++)
                        if (nb_win[s][j] != 8'hff) nb_win[s][j]++;
                end
                else if (nb_count < etx_pkg::MAX_NEIGHBORS)
                begin
                    s = nb_count;
                    nb_addr[s] = it.src;
                    for (int j = 0; j < etx_pkg::WINDOW; j++) nb_win[s][j] = 8'd1;
                    nb_count++;
                end
                else
                begin
                    pending_results.push_back(mk(etx_pkg::KIND_STATUS, etx_pkg::ST_FULL,
                        it.src, '0, 1'b0));
                    return;
                end
                if (it.no_entries)
                begin
                    pending_results.push_back(mk(etx_pkg::KIND_STATUS,
                        etx_pkg::ST_NOT_LISTED, it.src, '0, 1'b0));
                    return;
                end
                open_slot = s;
                open_ok = 1;
            end
            etx_pkg::REQ_ENTRY:
            begin
                if (!open_ok) return;
                if (!host_heard && it.eaddr == nb_host)
                begin
                    nb_fwd[open_slot] = it.ecount;
                    host_heard = 1;
                end
                if (it.elast)
                begin
                    pending_results.push_back(mk(etx_pkg::KIND_STATUS,
                        host_heard ? etx_pkg::ST_OK : etx_pkg::ST_NOT_LISTED,
                        nb_addr[open_slot], '0, 1'b0));
                    open_ok = 0;
                    host_heard = 0;
                end
            end
            etx_pkg::REQ_TICK:
            begin
                for (int i = 0; i < nb_count; i++)
                begin
                    h = nb_head[i];
                    r = int'(nb_win[i][h]);
                    f = int'(nb_fwd[i]);
                    nb_cost[i] = (r == 0 || f == 0) ? etx_pkg::COST_INF
                        : 20'((etx_pkg::WINDOW * etx_pkg::WINDOW) / (r * f));
                    nb_win[i][h] = '0;
                    nb_head[i] = (h + 1) % etx_pkg::WINDOW;
                end
                for (int i = 0; i < nb_count; i++)
                    pending_results.push_back(mk(etx_pkg::KIND_OUTGOING, etx_pkg::ST_OK,
                        nb_addr[i], 20'(nb_win[i][nb_head[i]]), i + 1 == nb_count));
            end
            default:
            begin
                s = lookup_neighbor(it.qaddr);
                if (s >= 0)
                    pending_results.push_back(mk(etx_pkg::KIND_COST, etx_pkg::ST_OK,
                        it.qaddr, nb_cost[s], 1'b0));
                else
                    pending_results.push_back(mk(etx_pkg::KIND_COST,
                        etx_pkg::ST_NOT_LISTED, it.qaddr, etx_pkg::COST_INF, 1'b0));
            end
        endcase
    endtask

    task automatic idle_clocks(int n);
        repeat (n) @(posedge clk);
    endtask

    // The valid line stays high after a beat; the next call or an idle burst changes it.
    task automatic send_beat(probe_row_t it);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            idle_clocks($urandom_range(1, 10));
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.req;
        s_tlast <= it.elast;
        s_tdata <= {7'b0, it.qaddr, it.ecount, it.eaddr, it.no_entries, it.src};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        update_table(it);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        idle_clocks(800);
    endtask

    task automatic write_host(logic [31:0] a);
        host_address_we <= 1'b1;
        host_address_wdata <= a;
        @(posedge clk);
        host_address_we <= 1'b0;
        nb_host = a;
    endtask

    // Output side: stall bursts, compare against the oldest expectation.
    always @(posedge clk)
    begin
        etx_result_t got;
        etx_result_t exp_r;
        if (rst_n)
        begin
            cycles <= cycles + 1;
            if (m_tvalid && m_tready)
            begin
                got = mk(m_tuser, m_tdata[1:0], m_tdata[33:2], m_tdata[53:34], m_tlast);
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result beat kind=%0d addr=%h", got.kind, got.addr);
                    errors++;
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (got.kind !== exp_r.kind)
                        begin $error("result_kind exp %0d got %0d", exp_r.kind, got.kind); errors++; end
                    if (got.status !== exp_r.status)
                        begin $error("status exp %0d got %0d", exp_r.status, got.status); errors++; end
                    if (got.addr !== exp_r.addr)
                        begin $error("neighbor_address exp %h got %h", exp_r.addr, got.addr); errors++; end
                    if (got.value !== exp_r.value)
                        begin $error("result_value exp %0d got %0d", exp_r.value, got.value); errors++; end
                    if (got.last !== exp_r.last)
                        begin $error("last_result exp %0d got %0d", exp_r.last, got.last); errors++; end
                end
            end
            if (quiet)
            begin
                stall_left = 0;
                m_tready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 10) - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles > 3000000)
        begin
            $display("link_etx_neighbor_table verification failed");
            $finish;
        end
    end

    function automatic probe_row_t row(logic [1:0] rq, logic [31:0] a, logic ne,
                                       logic [31:0] ea, logic [7:0] ec, logic el);
        probe_row_t r;
        r.req = rq; r.src = a; r.no_entries = ne; r.eaddr = ea; r.ecount = ec;
        r.elast = el; r.qaddr = a; r.has_fixed = 0; r.fixed = '0;
        return r;
    endfunction

    probe_row_t directed [$];
    probe_row_t it;
    logic [31:0] host_pool [4];

    initial
    begin
        table_reset();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_host(32'hffffffff);

        // Query before anything is known, then fill the table past its capacity.
        it = row(etx_pkg::REQ_QUERY, 32'h0, 1'b0, '0, '0, 1'b0);
        it.has_fixed = 1;
        it.fixed = mk(etx_pkg::KIND_COST, etx_pkg::ST_NOT_LISTED, '0, etx_pkg::COST_INF, 1'b0);
        directed.push_back(it);
        directed.push_back(row(etx_pkg::REQ_TICK, '0, 1'b0, '0, '0, 1'b0));
        directed.push_back(row(etx_pkg::REQ_ENTRY, '0, 1'b0, 32'hffffffff, 8'hff, 1'b1)); // stray entry
        directed.push_back(row(etx_pkg::REQ_HEADER, 32'h0, 1'b0, '0, '0, 1'b0));
        directed.push_back(row(etx_pkg::REQ_ENTRY, '0, 1'b0, 32'hffffffff, 8'hff, 1'b0));
        directed.push_back(row(etx_pkg::REQ_ENTRY, '0, 1'b0, 32'hffffffff, 8'h00, 1'b1)); // second host entry
        directed.push_back(row(etx_pkg::REQ_HEADER, 32'hffffffff, 1'b1, '0, '0, 1'b0));
        directed.push_back(row(etx_pkg::REQ_HEADER, 32'h1, 1'b0, '0, '0, 1'b0));
        directed.push_back(row(etx_pkg::REQ_HEADER, 32'h2, 1'b0, '0, '0, 1'b0));            // abandons probe
        directed.push_back(row(etx_pkg::REQ_ENTRY, '0, 1'b0, 32'hffffffff, 8'h00, 1'b1));  // zero forward
        for (int i = 3; i < 10; i++)
            directed.push_back(row(etx_pkg::REQ_HEADER, 32'h100 + i, 1'b1, '0, '0, 1'b0));
        it = row(etx_pkg::REQ_HEADER, 32'hdeadbeef, 1'b0, '0, '0, 1'b0);
        it.has_fixed = 1;
        it.fixed = mk(etx_pkg::KIND_STATUS, etx_pkg::ST_FULL, 32'hdeadbeef, '0, 1'b0);
        directed.push_back(it);
        directed.push_back(row(etx_pkg::REQ_ENTRY, '0, 1'b0, 32'hffffffff, 8'h5, 1'b1));   // ignored
        directed.push_back(row(etx_pkg::REQ_TICK, '0, 1'b0, '0, '0, 1'b0));
        directed.push_back(row(etx_pkg::REQ_QUERY, 32'h0, 1'b0, '0, '0, 1'b0));
        directed.push_back(row(etx_pkg::REQ_QUERY, 32'h2, 1'b0, '0, '0, 1'b0));

        foreach (directed[k])
        begin
            if (directed[k].has_fixed)
            begin
                update_table(directed[k]);
                if (pending_results[$] !== directed[k].fixed)
                begin
                    $error("directed row %0d: table predicts a different result", k);
                    errors++;
                end
                void'(pending_results.pop_back());
                pending_results.push_back(directed[k].fixed);
                // Replay the handshake without updating the shadow table twice.
                s_tvalid <= 1'b1;
                s_tuser <= directed[k].req;
                s_tlast <= directed[k].elast;
                s_tdata <= {7'b0, directed[k].qaddr, directed[k].ecount, directed[k].eaddr,
                            directed[k].no_entries, directed[k].src};
                @(posedge clk);
                while (!s_tready) @(posedge clk);
            end
            else
                send_beat(directed[k]);
        end
        wait_drained();

        // Three random phases with different hosts; neighbors saturate over time.
        for (int ph = 0; ph < 3; ph++)
        begin
            host_pool[0] = (ph == 2) ? 32'h0 : $urandom;
            write_host(host_pool[0]);
            for (int k = 0; k < 45; k++)
            begin
                logic [31:0] who;
                int ne;
                if (ph == 2 && k > 30) quiet = 1;
                if (k == 20) wait_drained();
                who = ($urandom_range(0, 9) == 0) ? $urandom
                    : nb_addr[$urandom_range(0, nb_count - 1)];
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4:
                    begin
                        ne = $urandom_range(0, 3);
                        send_beat(row(etx_pkg::REQ_HEADER, who, ne == 0, '0, '0, 1'b0));
                        for (int e = 0; ne != 0 && e < ne; e++)
                            send_beat(row(etx_pkg::REQ_ENTRY, '0, 1'($urandom),
                                ($urandom_range(0, 1)) ? nb_host : $urandom,
                                8'($urandom), e == ne - 1 || $urandom_range(0, 7) == 0));
                    end
                    5: send_beat(row(etx_pkg::REQ_ENTRY, $urandom, 1'($urandom), $urandom,
                                     8'($urandom), 1'($urandom)));
                    6, 7: send_beat(row(etx_pkg::REQ_TICK, $urandom, 1'($urandom), $urandom,
                                        8'($urandom), 1'($urandom)));
                    default: send_beat(row(etx_pkg::REQ_QUERY, who, 1'b0, '0, '0, 1'b0));
                endcase
            end
            wait_drained();
        end

        if (errors == 0)
            $display("link_etx_neighbor_table verification clean");
        else
            $display("link_etx_neighbor_table verification failed");
        $finish;
    end
endmodule
